>>> rtl/bcts_pkg.sv
// ----------------------------------------------------------------------------
// bcts_pkg
// Shared types, codes and helpers for the battery charge test sequencer.
// ----------------------------------------------------------------------------
package bcts_pkg;

  localparam int unsigned PCT_W      = 7;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned OUT_DATA_W = 16;
  localparam int unsigned ENTRY_W    = 7;

  localparam logic [PCT_W-1:0] PCT_MAX          = 7'd100;
  localparam logic [PCT_W-1:0] UPPER_RESET      = 7'd80;
  localparam logic [PCT_W-1:0] LOWER_RESET      = 7'd10;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_UPPER_TARGET = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOWER_TARGET = 1'b1;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_COMPARE  = 4'd1,
    PH_HOLD_UP1 = 4'd2,
    PH_CHG_UP1  = 4'd3,
    PH_DIS_UP1  = 4'd4,
    PH_DIS_LO   = 4'd5,
    PH_HOLD_LO  = 4'd6,
    PH_CHG_UP2  = 4'd7,
    PH_HOLD_UP2 = 4'd8
  } phase_t;

  typedef enum logic [1:0] {
    REP_NONE       = 2'd0,
    REP_UPPER_FIRST = 2'd1,
    REP_LOWER      = 2'd2,
    REP_UPPER_LAST = 2'd3
  } report_t;

  // input item, last member lands in bit 0
  typedef struct packed {
    logic             wait_done;
    logic [PCT_W-1:0] soc_percent;
    logic             hold_at_thirty;
    logic             keep_alive_busy;
    logic             set_autotest;
    logic             set_cycle;
  } item_t;

  // result item, last member lands in bit 0
  typedef struct packed {
    phase_t  phase;
    logic    cycle_done;
    report_t report_code;
    logic    param_check;
    logic    timer_clear;
    logic    timer_run;
    logic    drive_update;
    logic    discharge_on;
    logic    charge_on;
  } result_t;

  typedef struct packed {
    phase_t             phase;
    logic [ENTRY_W-1:0] entry_done;
    logic               cycle_active;
    logic               autotest_active;
    logic               params_checked;
    logic               charge;
    logic               discharge;
    logic               timer_run;
  } seq_state_t;

  localparam seq_state_t STATE_RESET = '{
    phase:           PH_IDLE,
    entry_done:      '0,
    cycle_active:    1'b0,
    autotest_active: 1'b0,
    params_checked:  1'b0,
    charge:          1'b0,
    discharge:       1'b0,
    timer_run:       1'b0
  };

  function automatic logic [PCT_W-1:0] clamp_pct(input logic [PCT_W-1:0] v);
    return (v > PCT_MAX) ? PCT_MAX : v;
  endfunction

endpackage

>>> rtl/bcts_step.sv
// ----------------------------------------------------------------------------
// bcts_step
// Next-state and result logic for one poll of the charge test sequencer.
// ----------------------------------------------------------------------------
module bcts_step (
  input  bcts_pkg::item_t                   item,
  input  bcts_pkg::seq_state_t              cur,
  input  logic [bcts_pkg::PCT_W-1:0]        upper_target,
  input  logic [bcts_pkg::PCT_W-1:0]        lower_target,
  output bcts_pkg::seq_state_t              nxt,
  output bcts_pkg::result_t                 res
);

  logic [bcts_pkg::PCT_W-1:0]   soc;
  logic [bcts_pkg::PCT_W-1:0]   up;
  logic [bcts_pkg::PCT_W-1:0]   lo;
  logic [bcts_pkg::PCT_W-1:0]   tgt;
  logic [2:0]                   ent_idx;
  logic [bcts_pkg::ENTRY_W-1:0] ent_bit;
  logic                         ent_seen;
  logic                         chg_phase;
  logic                         upd;
  logic                         clr;
  logic                         pchk;
  logic                         done;
  bcts_pkg::report_t            rep;

  assign soc = bcts_pkg::clamp_pct(item.soc_percent);
  assign up  = bcts_pkg::clamp_pct(upper_target);
  assign lo  = bcts_pkg::clamp_pct(lower_target);

  always_comb begin
    nxt       = cur;
    upd       = 1'b0;
    clr       = 1'b0;
    pchk      = 1'b0;
    done      = 1'b0;
    rep       = bcts_pkg::REP_NONE;
    ent_idx   = 3'd0;
    ent_bit   = '0;
    ent_seen  = 1'b0;
    chg_phase = 1'b0;
    tgt       = up;

    if (item.set_cycle) nxt.cycle_active = 1'b1;
    if (item.set_autotest) nxt.autotest_active = 1'b1;

    if (!item.keep_alive_busy && nxt.cycle_active && !item.hold_at_thirty) begin
      if (nxt.phase == bcts_pkg::PH_IDLE) begin
        nxt.charge    = 1'b0;
        nxt.discharge = 1'b0;
        upd           = 1'b1;
      end
      if (nxt.autotest_active) begin
        if (!nxt.params_checked) begin
          nxt.params_checked = 1'b1;
          pchk               = 1'b1;
        end
        if (nxt.phase == bcts_pkg::PH_IDLE) nxt.phase = bcts_pkg::PH_COMPARE;

        // one entry flag per phase from hold-at-upper onward
        ent_idx   = 3'(nxt.phase - 4'd2);
        ent_bit   = bcts_pkg::ENTRY_W'(1) << ent_idx;
        ent_seen  = |(nxt.entry_done & ent_bit);
        chg_phase = (nxt.phase == bcts_pkg::PH_CHG_UP1) ||
                    (nxt.phase == bcts_pkg::PH_CHG_UP2);
        tgt       = (nxt.phase == bcts_pkg::PH_DIS_LO) ? lo : up;

        case (nxt.phase)
          bcts_pkg::PH_COMPARE: begin
            if (soc == up)     nxt.phase = bcts_pkg::PH_HOLD_UP1;
            else if (soc < up) nxt.phase = bcts_pkg::PH_CHG_UP1;
            else               nxt.phase = bcts_pkg::PH_DIS_UP1;
          end
          bcts_pkg::PH_HOLD_UP1, bcts_pkg::PH_HOLD_LO, bcts_pkg::PH_HOLD_UP2: begin
            if (!ent_seen) begin
              nxt.charge     = 1'b0;
              nxt.discharge  = 1'b0;
              upd            = 1'b1;
              nxt.timer_run  = 1'b1;
              nxt.entry_done = nxt.entry_done | ent_bit;
            end else if (item.wait_done) begin
              nxt.entry_done = nxt.entry_done & ~ent_bit;
              if (nxt.phase == bcts_pkg::PH_HOLD_UP1) begin
                rep       = bcts_pkg::REP_UPPER_FIRST;
                nxt.phase = bcts_pkg::PH_DIS_LO;
              end else if (nxt.phase == bcts_pkg::PH_HOLD_LO) begin
                rep       = bcts_pkg::REP_LOWER;
                nxt.phase = bcts_pkg::PH_CHG_UP2;
              end else begin
                rep                 = bcts_pkg::REP_UPPER_LAST;
                nxt.timer_run       = 1'b0;
                clr                 = 1'b1;
                nxt.autotest_active = 1'b0;
                nxt.cycle_active    = 1'b0;
                nxt.params_checked  = 1'b0;
                nxt.phase           = bcts_pkg::PH_IDLE;
                done                = 1'b1;
              end
            end
          end
          bcts_pkg::PH_CHG_UP1, bcts_pkg::PH_DIS_UP1, bcts_pkg::PH_DIS_LO,
          bcts_pkg::PH_CHG_UP2: begin
            if (!ent_seen) begin
              nxt.charge    = chg_phase;
              nxt.discharge = !chg_phase;
              upd           = 1'b1;
              if (nxt.phase == bcts_pkg::PH_DIS_LO || nxt.phase == bcts_pkg::PH_CHG_UP2) begin
                nxt.timer_run = 1'b0;
                clr           = 1'b1;
              end
              nxt.entry_done = nxt.entry_done | ent_bit;
            end else if (soc == tgt) begin
              nxt.entry_done = nxt.entry_done & ~ent_bit;
              if (nxt.phase == bcts_pkg::PH_DIS_LO)       nxt.phase = bcts_pkg::PH_HOLD_LO;
              else if (nxt.phase == bcts_pkg::PH_CHG_UP2) nxt.phase = bcts_pkg::PH_HOLD_UP2;
              else                                        nxt.phase = bcts_pkg::PH_HOLD_UP1;
            end
          end
          default: begin
            nxt.phase = bcts_pkg::PH_IDLE;
          end
        endcase
      end
    end
  end

  always_comb begin
    res.charge_on    = nxt.charge;
    res.discharge_on = nxt.discharge;
    res.drive_update = upd;
    res.timer_run    = nxt.timer_run;
    res.timer_clear  = clr;
    res.param_check  = pchk;
    res.report_code  = rep;
    res.cycle_done   = done;
    res.phase        = nxt.phase;
  end

endmodule

>>> rtl/bcts_out_buf.sv
// ----------------------------------------------------------------------------
// bcts_out_buf
// Result register for the master-side stream, with backpressure.
// ----------------------------------------------------------------------------
module bcts_out_buf (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                load,
  input  bcts_pkg::result_t                   res,
  output logic                                can_load,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [bcts_pkg::OUT_DATA_W-1:0]     out_tdata
);

  logic              valid_r;
  logic              valid_nxt;
  bcts_pkg::result_t data_r;

  // a new result may replace the held one in the same cycle it is taken
  assign can_load  = !valid_r || out_tready;
  assign valid_nxt = load || (valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= res;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {(bcts_pkg::OUT_DATA_W - $bits(bcts_pkg::result_t))'(0), data_r};

endmodule

>>> rtl/battery_charge_test_sequencer.sv
// ----------------------------------------------------------------------------
// battery_charge_test_sequencer
// Poll-driven sequencer for a battery charge and discharge test.
// ----------------------------------------------------------------------------
// Each poll is one transfer on the in_ stream and yields exactly one result
// transfer on the out_ stream. A poll is latched into an input register, the
// phase logic is combinational and the result lands in an output register,
// so a poll passes the input and then the output register before its result
// is valid on out_. One poll is accepted every cycle as long as the output
// side keeps taking results. The sequencer state (phase, entry flags, switch
// and timer levels) updates once per poll, in order. The user must write
// targets through cfg_ only while no poll is in flight; the block does not
// enforce this. Readings and targets above 100 are treated as 100.
module battery_charge_test_sequencer (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration write port
  input  logic                                cfg_wr_en,
  input  logic [bcts_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bcts_pkg::PCT_W-1:0]          cfg_wdata,
  // poll stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [0] set_cycle, [1] set_autotest, [2] keep_alive_busy, [3] hold_at_thirty,
  // [10:4] soc_percent, [11] wait_done, [15:12] zero
  input  logic [bcts_pkg::IN_DATA_W-1:0]      in_tdata,
  // result stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [0] charge_on, [1] discharge_on, [2] drive_update, [3] timer_run,
  // [4] timer_clear, [5] param_check, [7:6] report_code, [8] cycle_done,
  // [12:9] phase, [15:13] zero
  output logic [bcts_pkg::OUT_DATA_W-1:0]     out_tdata
);

  logic                         upper_sel;
  logic [bcts_pkg::PCT_W-1:0]   upper_target_r;
  logic [bcts_pkg::PCT_W-1:0]   lower_target_r;
  logic                         s1_valid_r;
  logic                         s1_valid_nxt;
  bcts_pkg::item_t              s1_item_r;
  logic                         in_fire;
  logic                         s1_fire;
  logic                         buf_ready;
  bcts_pkg::seq_state_t         state_r;
  bcts_pkg::seq_state_t         state_nxt;
  bcts_pkg::result_t            res;

  assign upper_sel = (cfg_index == bcts_pkg::CFG_UPPER_TARGET);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upper_target_r <= bcts_pkg::UPPER_RESET;
      lower_target_r <= bcts_pkg::LOWER_RESET;
    end else if (cfg_wr_en) begin
      if (upper_sel) begin
        upper_target_r <= cfg_wdata;
      end
      if (cfg_index == bcts_pkg::CFG_LOWER_TARGET) begin
        lower_target_r <= cfg_wdata;
      end
    end
  end

  // input register
  assign s1_fire      = s1_valid_r && buf_ready;
  assign in_tready    = !s1_valid_r || buf_ready;
  assign in_fire      = in_tvalid && in_tready;
  assign s1_valid_nxt = in_fire || (s1_valid_r && !s1_fire);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r <= bcts_pkg::item_t'(in_tdata[$bits(bcts_pkg::item_t)-1:0]);
    end
  end

  bcts_step u_step (
    .item         (s1_item_r),
    .cur          (state_r),
    .upper_target (upper_target_r),
    .lower_target (lower_target_r),
    .nxt          (state_nxt),
    .res          (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bcts_pkg::STATE_RESET;
    end else if (s1_fire) begin
      state_r <= state_nxt;
    end
  end

  bcts_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (s1_fire),
    .res        (res),
    .can_load   (buf_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

`ifndef SYNTH
  a_switch_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(state_r.charge && state_r.discharge))
    else $error("charge and discharge commanded together");

  a_entry_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(state_r.entry_done))
    else $error("more than one phase entry flag set");

  a_idle_no_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.phase == bcts_pkg::PH_IDLE || state_r.phase == bcts_pkg::PH_COMPARE)
      |-> (state_r.entry_done == '0))
    else $error("entry flag left set outside the run phases");

  a_done_clears_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && res.cycle_done) |=> (!state_r.cycle_active && !state_r.timer_run &&
      state_r.phase == bcts_pkg::PH_IDLE))
    else $error("cycle finish did not return to idle");
`endif

endmodule
